### rtl/core/vau_pkg.sv
package vau_pkg;

  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [2:0] {
    CMD_ADD,
    CMD_SUB,
    CMD_DOT,
    CMD_CROSS,
    CMD_SCALE,
    CMD_SQNORM,
    CMD_NORM,
    CMD_NORMALIZE
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SAT,
    ST_ZERO
  } status_t;

endpackage

### rtl/core/vau_stream_if.sv
interface vau_in_if;
  logic               valid;
  logic               ready;
  vau_pkg::cmd_t      cmd;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] scale_factor;

  modport source (
    output valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
    input  ready
  );
  modport sink (
    input  valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
    output ready
  );
endinterface

interface vau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r_x;
  logic signed [31:0] r_y;
  logic signed [31:0] r_z;
  logic signed [63:0] r_scalar;
  vau_pkg::status_t   status;

  modport source (
    output valid, r_x, r_y, r_z, r_scalar, status,
    input  ready
  );
  modport sink (
    input  valid, r_x, r_y, r_z, r_scalar, status,
    output ready
  );
endinterface

### rtl/core/vec3_arithmetic_unit_top.sv
// Channel   Direction  Handshake      Payload
// in_chan   input      valid/ready    cmd, a_x..a_z, b_x..b_z, scale_factor
// out_chan  output     valid/ready    r_x, r_y, r_z, r_scalar, status
//
// One transaction per cycle is sustained while out_chan does not stall.
// Most of the pipeline depth is the square root, one result bit per stage, followed
// by the normalizing divide, one quotient bit per stage.
// Every stage carries a valid bit and loads when it is empty or its content
// moves on, so bubbles close up and a stall on out_chan loses nothing.
// Reset is synchronous and clears only the valid bits.
module vec3_arithmetic_unit_top #(
  parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  vau_in_if.sink    in_chan,
  vau_out_if.source out_chan
);

  localparam int SQ    = 32 + FRAC_BITS;
  localparam int NW    = 32 + FRAC_BITS;
  localparam int SRW   = 36 + FRAC_BITS;
  localparam int DV    = FRAC_BITS + 1;
  localparam int DRW   = 34 + FRAC_BITS;
  localparam int QW    = FRAC_BITS + 1;
  localparam int S_MUL = 1;
  localparam int S_CMB = 2;
  localparam int S_SAT = 3;
  localparam int S_SQ0 = 4;
  localparam int S_DV0 = S_SQ0 + SQ;
  localparam int S_OUT = S_DV0 + DV;
  localparam logic signed [31:0] UNIT = 32'sd1 <<< FRAC_BITS;

  function automatic logic ovf32(input logic signed [64:0] v);
    return !((v[64:31] == '0) || (v[64:31] == '1));
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (ovf32(v)) begin
      return v[64] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  logic [S_OUT:0]     ld;
  logic               v_r    [0:S_OUT];
  vau_pkg::cmd_t      cmd_r  [0:S_OUT-1];
  logic signed [31:0] a_r    [0:S_OUT-1][3];
  logic signed [31:0] b0_r   [3];
  logic signed [31:0] s0_r;
  logic signed [31:0] mul_a  [6];
  logic signed [31:0] mul_b  [6];
  logic signed [63:0] p_nxt  [6];
  logic signed [63:0] p_r    [6];
  logic signed [32:0] as_nxt [3];
  logic signed [32:0] as_r   [3];
  logic signed [64:0] pre_nxt [3];
  logic signed [64:0] pre_r  [3];
  logic signed [65:0] wsum_nxt;
  logic signed [65:0] wsum_r;
  logic [63:0]        sq_r   [S_CMB:S_DV0-1];
  logic signed [31:0] rv_nxt [3];
  logic signed [63:0] sc_nxt;
  logic               sat_nxt;
  logic signed [31:0] rv_r   [S_SAT:S_OUT-1][3];
  logic signed [63:0] sc_r   [S_SAT:S_OUT-1];
  logic               sat_r  [S_SAT:S_OUT-1];
  logic [SRW-1:0]     rem_r  [S_SQ0:S_DV0-1];
  logic [NW-1:0]      root_r [S_SQ0:S_OUT-1];
  logic [DRW-1:0]     drem_r [S_DV0:S_OUT-1][3];
  logic [QW-1:0]      q_r    [S_DV0:S_OUT-1][3];
  logic signed [31:0] res_nxt [3];
  logic signed [31:0] res_r  [3];
  logic signed [63:0] osc_nxt;
  logic signed [63:0] osc_r;
  vau_pkg::status_t   ost_nxt;
  vau_pkg::status_t   ost_r;
  vau_pkg::cmd_t      ocmd_r;

  assign ld[S_OUT]     = !v_r[S_OUT] || out_chan.ready;
  assign in_chan.ready = ld[0];

  assign out_chan.valid    = v_r[S_OUT];
  assign out_chan.r_x      = res_r[0];
  assign out_chan.r_y      = res_r[1];
  assign out_chan.r_z      = res_r[2];
  assign out_chan.r_scalar = osc_r;
  assign out_chan.status   = ost_r;

  // Load chain and per-stage valid bits.
  for (genvar k = 0; k < S_OUT; k++) begin : g_ld
    assign ld[k] = !v_r[k] || ld[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (ld[0]) begin
      v_r[0] <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      cmd_r[0]  <= in_chan.cmd;
      a_r[0][0] <= in_chan.a_x;
      a_r[0][1] <= in_chan.a_y;
      a_r[0][2] <= in_chan.a_z;
      b0_r[0]   <= in_chan.b_x;
      b0_r[1]   <= in_chan.b_y;
      b0_r[2]   <= in_chan.b_z;
      s0_r      <= in_chan.scale_factor;
    end
  end

  for (genvar k = 1; k <= S_OUT; k++) begin : g_valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ld[k]) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  for (genvar k = 1; k < S_OUT; k++) begin : g_carry
    always_ff @(posedge clk) begin
      if (ld[k]) begin
        cmd_r[k] <= cmd_r[k-1];
        a_r[k]   <= a_r[k-1];
      end
    end
  end

  // Multiply stage: six shared multipliers, operands chosen by the opcode.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      mul_a[i] = '0;
      mul_b[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      as_nxt[i] = '0;
    end
    case (cmd_r[0])
      vau_pkg::CMD_ADD: begin
        for (int i = 0; i < 3; i++) begin
          as_nxt[i] = 33'(a_r[0][i]) + 33'(b0_r[i]);
        end
      end
      vau_pkg::CMD_SUB: begin
        for (int i = 0; i < 3; i++) begin
          as_nxt[i] = 33'(a_r[0][i]) - 33'(b0_r[i]);
        end
      end
      vau_pkg::CMD_DOT: begin
        for (int i = 0; i < 3; i++) begin
          mul_a[i] = a_r[0][i];
          mul_b[i] = b0_r[i];
        end
      end
      vau_pkg::CMD_CROSS: begin
        mul_a[0] = a_r[0][1]; mul_b[0] = b0_r[2];
        mul_a[1] = a_r[0][2]; mul_b[1] = b0_r[1];
        mul_a[2] = a_r[0][2]; mul_b[2] = b0_r[0];
        mul_a[3] = a_r[0][0]; mul_b[3] = b0_r[2];
        mul_a[4] = a_r[0][0]; mul_b[4] = b0_r[1];
        mul_a[5] = a_r[0][1]; mul_b[5] = b0_r[0];
      end
      vau_pkg::CMD_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          mul_a[i] = a_r[0][i];
          mul_b[i] = s0_r;
        end
      end
      vau_pkg::CMD_SQNORM, vau_pkg::CMD_NORM, vau_pkg::CMD_NORMALIZE: begin
        for (int i = 0; i < 3; i++) begin
          mul_a[i] = a_r[0][i];
          mul_b[i] = a_r[0][i];
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 6; i++) begin
      p_nxt[i] = 64'(mul_a[i]) * 64'(mul_b[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[S_MUL]) begin
      p_r  <= p_nxt;
      as_r <= as_nxt;
    end
  end

  // Combine stage: differences and sums of products; add/sub results and scale products pass through.
  always_comb begin
    wsum_nxt = 66'(p_r[0]) + 66'(p_r[1]) + 66'(p_r[2]);
    for (int i = 0; i < 3; i++) begin
      pre_nxt[i] = '0;
    end
    case (cmd_r[S_MUL])
      vau_pkg::CMD_ADD, vau_pkg::CMD_SUB: begin
        for (int i = 0; i < 3; i++) begin
          pre_nxt[i] = 65'(as_r[i]);
        end
      end
      vau_pkg::CMD_CROSS: begin
        pre_nxt[0] = 65'(p_r[0]) - 65'(p_r[1]);
        pre_nxt[1] = 65'(p_r[2]) - 65'(p_r[3]);
        pre_nxt[2] = 65'(p_r[4]) - 65'(p_r[5]);
      end
      vau_pkg::CMD_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          pre_nxt[i] = 65'(p_r[i]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[S_CMB]) begin
      pre_r        <= pre_nxt;
      wsum_r       <= wsum_nxt;
      sq_r[S_CMB]  <= wsum_nxt[63:0];
    end
  end

  // Shift and saturate stage.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rv_nxt[i] = '0;
    end
    sc_nxt  = '0;
    sat_nxt = 1'b0;
    case (cmd_r[S_CMB])
      vau_pkg::CMD_ADD, vau_pkg::CMD_SUB: begin
        for (int i = 0; i < 3; i++) begin
          rv_nxt[i] = sat32(pre_r[i]);
          sat_nxt   = sat_nxt | ovf32(pre_r[i]);
        end
      end
      vau_pkg::CMD_CROSS, vau_pkg::CMD_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          rv_nxt[i] = sat32(pre_r[i] >>> FRAC_BITS);
          sat_nxt   = sat_nxt | ovf32(pre_r[i] >>> FRAC_BITS);
        end
      end
      vau_pkg::CMD_DOT: begin
        if ((wsum_r[65:63] == 3'b000) || (wsum_r[65:63] == 3'b111)) begin
          sc_nxt = wsum_r[63:0];
        end else begin
          sat_nxt = 1'b1;
          sc_nxt  = wsum_r[65] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
      end
      vau_pkg::CMD_SQNORM: begin
        if (sq_r[S_CMB][63]) begin
          sat_nxt = 1'b1;
          sc_nxt  = 64'sh7FFF_FFFF_FFFF_FFFF;
        end else begin
          sc_nxt = sq_r[S_CMB];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[S_SAT]) begin
      rv_r[S_SAT]  <= rv_nxt;
      sc_r[S_SAT]  <= sc_nxt;
      sat_r[S_SAT] <= sat_nxt;
      sq_r[S_SAT]  <= sq_r[S_CMB];
    end
  end

  // Square root, one result bit per stage.
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam int K = S_SQ0 + j;
    localparam int I = SQ - 1 - j;
    logic [1:0]     pair;
    logic [SRW-1:0] rem_prev;
    logic [NW-1:0]  root_prev;
    logic [SRW-1:0] t;
    logic [SRW-1:0] trial;
    logic [SRW-1:0] rem_nxt;
    logic [NW-1:0]  root_nxt;

    if (I >= FRAC_BITS) begin : g_pair
      localparam int PB = 2 * (I - FRAC_BITS);
      assign pair = sq_r[K-1][PB+1 -: 2];
    end else begin : g_nopair
      assign pair = 2'b00;
    end

    if (j == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
    end else begin : g_next
      assign rem_prev  = rem_r[K-1];
      assign root_prev = root_r[K-1];
    end

    always_comb begin
      t     = {rem_prev[SRW-3:0], pair};
      trial = SRW'({root_prev, 2'b01});
      if (t >= trial) begin
        rem_nxt  = t - trial;
        root_nxt = {root_prev[NW-2:0], 1'b1};
      end else begin
        rem_nxt  = t;
        root_nxt = {root_prev[NW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (ld[K]) begin
        rem_r[K]  <= rem_nxt;
        root_r[K] <= root_nxt;
        sq_r[K]   <= sq_r[K-1];
        rv_r[K]   <= rv_r[K-1];
        sc_r[K]   <= sc_r[K-1];
        sat_r[K]  <= sat_r[K-1];
      end
    end
  end

  // Normalizing divide, one quotient bit per stage for each component.
  for (genvar d = 0; d < DV; d++) begin : g_div
    localparam int K = S_DV0 + d;
    logic [DRW-1:0] n;
    logic [DRW-1:0] t       [3];
    logic [DRW-1:0] drem_nxt [3];
    logic [QW-1:0]  q_nxt   [3];
    logic [QW-1:0]  q_prev  [3];

    assign n = DRW'(root_r[K-1]);

    for (genvar i = 0; i < 3; i++) begin : g_lane
      if (d == 0) begin : g_first
        logic [31:0] mag;
        assign mag       = a_r[K-1][i][31] ? 32'(-a_r[K-1][i]) : 32'(a_r[K-1][i]);
        assign t[i]      = DRW'({mag, {FRAC_BITS{1'b0}}});
        assign q_prev[i] = '0;
      end else begin : g_next
        assign t[i]      = {drem_r[K-1][i][DRW-2:0], 1'b0};
        assign q_prev[i] = q_r[K-1][i];
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (t[i] >= n) begin
          drem_nxt[i] = t[i] - n;
          q_nxt[i]    = {q_prev[i][QW-2:0], 1'b1};
        end else begin
          drem_nxt[i] = t[i];
          q_nxt[i]    = {q_prev[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ld[K]) begin
        drem_r[K] <= drem_nxt;
        q_r[K]    <= q_nxt;
        root_r[K] <= root_r[K-1];
        rv_r[K]   <= rv_r[K-1];
        sc_r[K]   <= sc_r[K-1];
        sat_r[K]  <= sat_r[K-1];
      end
    end
  end

  // Output stage.
  always_comb begin
    logic signed [31:0] qx;
    res_nxt = rv_r[S_OUT-1];
    osc_nxt = sc_r[S_OUT-1];
    ost_nxt = sat_r[S_OUT-1] ? vau_pkg::ST_SAT : vau_pkg::ST_OK;
    case (cmd_r[S_OUT-1])
      vau_pkg::CMD_NORM: begin
        osc_nxt = 64'(root_r[S_OUT-1]);
      end
      vau_pkg::CMD_NORMALIZE: begin
        if (root_r[S_OUT-1] == '0) begin
          ost_nxt = vau_pkg::ST_ZERO;
          for (int i = 0; i < 3; i++) begin
            res_nxt[i] = '0;
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            qx         = 32'(q_r[S_OUT-1][i]);
            res_nxt[i] = a_r[S_OUT-1][i][31] ? -qx : qx;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[S_OUT]) begin
      res_r  <= res_nxt;
      osc_r  <= osc_nxt;
      ost_r  <= ost_nxt;
      ocmd_r <= cmd_r[S_OUT-1];
    end
  end

  a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (ost_r == vau_pkg::ST_ZERO) |->
      (res_r[0] == '0) && (res_r[1] == '0) && (res_r[2] == '0) && (osc_r == '0))
    else $error("zero-length normalize returned nonzero fields");

  a_unit_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (ocmd_r == vau_pkg::CMD_NORMALIZE) && (ost_r == vau_pkg::ST_OK) |->
      (res_r[0] <= UNIT) && (res_r[0] >= -UNIT) && (res_r[1] <= UNIT) &&
      (res_r[1] >= -UNIT) && (res_r[2] <= UNIT) && (res_r[2] >= -UNIT))
    else $error("normalized component exceeds one");

  a_norm_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (ocmd_r == vau_pkg::CMD_NORM) |->
      !osc_r[63] && (ost_r == vau_pkg::ST_OK))
    else $error("norm negative or flagged");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    ld[S_OUT] && v_r[S_OUT-1] |=>
      out_chan.valid && (ocmd_r == $past(cmd_r[S_OUT-1])))
    else $error("last stage transaction did not reach the output");

endmodule

### sim/vau_result_checker.sv
`timescale 1ns / 100ps

module vau_result_checker #(
  parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  vau_in_if           in_mon,
  vau_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned checked,
  output int unsigned sat_seen,
  output int unsigned zero_seen
);
  import vau_pkg::*;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [63:0] r_scalar;
    status_t            status;
  } vec_result_t;

  vec_result_t expected_results[$];

  localparam logic signed [127:0] MAX32 = 128'sh7fffffff;
  localparam logic signed [127:0] MIN32 = -128'sh80000000;
  localparam logic signed [127:0] MAX64 = 128'sh7fffffffffffffff;
  localparam logic signed [127:0] MIN64 = -128'sh8000000000000000;

  function automatic logic signed [31:0] clamp_q16(input logic signed [127:0] v, ref bit sat);
    if (v > MAX32) begin
      sat = 1;
      return MAX32[31:0];
    end
    if (v < MIN32) begin
      sat = 1;
      return MIN32[31:0];
    end
    return v[31:0];
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [127:0] x);
    logic [127:0] root;
    logic [127:0] trial;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      trial = root | (128'd1 << i);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic vec_result_t compute_vector_op(
    input cmd_t op,
    input logic signed [31:0] ax, ay, az, bx, by, bz, sf
  );
    vec_result_t        res;
    logic signed [127:0] a[3];
    logic signed [127:0] b[3];
    logic signed [127:0] s;
    logic signed [127:0] t;
    logic [127:0]        sq;
    logic [127:0]        n;
    logic [127:0]        mag;
    logic [127:0]        q;
    bit                  sat;
    logic signed [31:0]  r[3];
    a[0] = ax; a[1] = ay; a[2] = az;
    b[0] = bx; b[1] = by; b[2] = bz;
    s = sf;
    sat = 0;
    r[0] = '0; r[1] = '0; r[2] = '0;
    res = '0;
    res.status = ST_OK;
    sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    case (op)
      CMD_ADD: begin
        for (int i = 0; i < 3; i++) r[i] = clamp_q16(a[i] + b[i], sat);
      end
      CMD_SUB: begin
        for (int i = 0; i < 3; i++) r[i] = clamp_q16(a[i] - b[i], sat);
      end
      CMD_DOT: begin
        t = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        if (t > MAX64) begin
          sat = 1;
          t = MAX64;
        end else if (t < MIN64) begin
          sat = 1;
          t = MIN64;
        end
        res.r_scalar = t[63:0];
      end
      CMD_CROSS: begin
        r[0] = clamp_q16((a[1] * b[2] - a[2] * b[1]) >>> FRAC_BITS, sat);
        r[1] = clamp_q16((a[2] * b[0] - a[0] * b[2]) >>> FRAC_BITS, sat);
        r[2] = clamp_q16((a[0] * b[1] - a[1] * b[0]) >>> FRAC_BITS, sat);
      end
      CMD_SCALE: begin
        for (int i = 0; i < 3; i++) r[i] = clamp_q16((a[i] * s) >>> FRAC_BITS, sat);
      end
      CMD_SQNORM: begin
        if (sq > MAX64) begin
          sat = 1;
          res.r_scalar = MAX64[63:0];
        end else begin
          res.r_scalar = sq[63:0];
        end
      end
      CMD_NORM: begin
        n = floor_sqrt(sq << (2 * FRAC_BITS));
        res.r_scalar = n[63:0];
      end
      default: begin
        if (sq == 0) begin
          res.status = ST_ZERO;
        end else begin
          n = floor_sqrt(sq << (2 * FRAC_BITS));
          for (int i = 0; i < 3; i++) begin
            mag = (a[i] < 0) ? -a[i] : a[i];
            q = (mag << (2 * FRAC_BITS)) / n;
            r[i] = (a[i] < 0) ? -q[31:0] : q[31:0];
          end
        end
      end
    endcase
    res.r_x = r[0];
    res.r_y = r[1];
    res.r_z = r[2];
    if (sat) res.status = ST_SAT;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
    sat_seen = 0;
    zero_seen = 0;
  end

  always @(posedge clk) begin
    vec_result_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        expected_results.push_back(compute_vector_op(in_mon.cmd, in_mon.a_x, in_mon.a_y,
          in_mon.a_z, in_mon.b_x, in_mon.b_y, in_mon.b_z, in_mon.scale_factor));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction", out_mon.r_scalar, '0);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (want.status == ST_SAT) sat_seen++;
          if (want.status == ST_ZERO) zero_seen++;
          if (out_mon.r_x !== want.r_x) report_mismatch("r_x", out_mon.r_x, want.r_x);
          if (out_mon.r_y !== want.r_y) report_mismatch("r_y", out_mon.r_y, want.r_y);
          if (out_mon.r_z !== want.r_z) report_mismatch("r_z", out_mon.r_z, want.r_z);
          if (out_mon.r_scalar !== want.r_scalar) begin
            report_mismatch("r_scalar", out_mon.r_scalar, want.r_scalar);
          end
          if (out_mon.status !== want.status) begin
            report_mismatch("status", out_mon.status, want.status);
          end
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

### sim/tb_vec3_arithmetic_unit_top.sv
`timescale 1ns / 100ps

module tb_vec3_arithmetic_unit_top;
  import vau_pkg::*;

  localparam int FRAC_BITS = FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS = 1030;
  localparam int CALM_AFTER = 900;
  localparam int LATENCY = 37 + 2 * FRAC_BITS;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [31:0] QMAX = 32'sh7fffffff;
  localparam logic signed [31:0] QMIN = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned sat_seen;
  int unsigned zero_seen;
  int unsigned cycles;
  int unsigned sent;
  bit          calm;
  bit          hold_request;

  vau_in_if  in_if ();
  vau_out_if out_if ();

  vec3_arithmetic_unit_top #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  vau_result_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .sat_seen   (sat_seen),
    .zero_seen  (zero_seen)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] pick_component();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5: return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
      6: return $signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
      7: begin
        case ($urandom_range(0, 5))
          0: return QMAX;
          1: return QMIN;
          2: return 0;
          3: return -1;
          4: return ONE;
          default: return -ONE;
        endcase
      end
      8: return 0;
      default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
    endcase
  endfunction

  task automatic send_item(input cmd_t op, input logic signed [31:0] ax, ay, az,
                           input logic signed [31:0] bx, by, bz, sf);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.cmd          <= op;
    in_if.a_x          <= ax;
    in_if.a_y          <= ay;
    in_if.a_z          <= az;
    in_if.b_x          <= bx;
    in_if.b_y          <= by;
    in_if.b_z          <= bz;
    in_if.scale_factor <= sf;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent++;
  endtask

  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_if.ready <= 1'b0;
        hold_request = 0;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    cmd_t op;
    sent = 0;
    calm = 0;
    hold_request = 0;
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.cmd          <= CMD_ADD;
    in_if.a_x          <= '0;
    in_if.a_y          <= '0;
    in_if.a_z          <= '0;
    in_if.b_x          <= '0;
    in_if.b_y          <= '0;
    in_if.b_z          <= '0;
    in_if.scale_factor <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CMD_ADD, QMAX, QMIN, ONE, ONE, -ONE, 5, 0);
    send_item(CMD_ADD, QMIN, QMAX, 0, -1, 1, 0, 0);
    send_item(CMD_SUB, QMIN, QMAX, 3, 1, -1, 7, 0);
    send_item(CMD_SUB, QMAX, QMIN, -ONE, QMIN, QMAX, ONE, 0);
    send_item(CMD_DOT, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 0);
    send_item(CMD_DOT, QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, 0);
    send_item(CMD_DOT, ONE, -ONE, 3, ONE, ONE, -7, 0);
    send_item(CMD_CROSS, QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, 0);
    send_item(CMD_CROSS, ONE, 0, 0, 0, ONE, 0, 0);
    send_item(CMD_CROSS, -3, 5, -7, 11, -13, 17, 0);
    send_item(CMD_SCALE, QMAX, QMIN, -1, 0, 0, 0, QMAX);
    send_item(CMD_SCALE, QMAX, QMIN, -3, 0, 0, 0, QMIN);
    send_item(CMD_SCALE, ONE, -ONE, 12345, 0, 0, 0, -ONE);
    send_item(CMD_SQNORM, QMIN, QMIN, QMIN, 0, 0, 0, 0);
    send_item(CMD_SQNORM, ONE, ONE, -ONE, 0, 0, 0, 0);
    send_item(CMD_NORM, QMIN, QMIN, QMIN, 0, 0, 0, 0);
    send_item(CMD_NORM, 0, 0, 0, 0, 0, 0, 0);
    send_item(CMD_NORM, 1, 0, 0, 0, 0, 0, 0);
    send_item(CMD_NORMALIZE, 0, 0, 0, QMAX, QMIN, 1, QMAX);
    send_item(CMD_NORMALIZE, QMIN, QMIN, QMIN, 0, 0, 0, 0);
    send_item(CMD_NORMALIZE, 0, -1, 0, 0, 0, 0, 0);
    send_item(CMD_NORMALIZE, QMAX, 1, -1, 0, 0, 0, 0);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 250) hold_request = 1;
      if (sent >= CALM_AFTER) calm = 1;
      op = cmd_t'($urandom_range(0, 7));
      send_item(op, pick_component(), pick_component(), pick_component(),
                pick_component(), pick_component(), pick_component(), pick_component());
    end
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("covered %0d transactions, %0d checked, over all eight operations",
             sent, checked);
    $display("saturated results: %0d, zero-length normalizes: %0d", sat_seen, zero_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
